// ===== rtl/core/midi_byte_receiver_sysex_assert.svh =====
// Assertion macros shared by the MIDI byte receiver RTL.
// They expect signals named clock and reset in the scope where they are used.
`ifndef MIDI_BYTE_RECEIVER_SYSEX_ASSERT_SVH
`define MIDI_BYTE_RECEIVER_SYSEX_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MBRS_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MBRS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/mbrs_pkg.sv =====
// Shared types, codes and constants of the MIDI byte receiver.
// No dependencies; every RTL module of the block imports it.
`default_nettype none

package mbrs_pkg;

   localparam int unsigned SAMPLE_DEPTH_DEF = 4096;
   localparam int unsigned QUEUE_DEPTH = 2;

   localparam logic [7:0] SYSEX_START = 8'hF0;
   localparam logic [7:0] SYSEX_END   = 8'hF7;
   localparam logic [7:0] CMD_VOLUME  = 8'h06;
   localparam logic [7:0] CMD_SAMPLE  = 8'h7F;

   localparam logic [3:0] NIB_SYSTEM   = 4'hF;
   localparam logic [3:0] NIB_NOTE_ON  = 4'h9;
   localparam logic [3:0] NIB_PROGRAM  = 4'hC;
   localparam logic [3:0] NIB_PRESSURE = 4'hD;

   localparam logic [2:0] KIND_NOTE    = 3'd0;
   localparam logic [2:0] KIND_FORWARD = 3'd1;
   localparam logic [2:0] KIND_VOLUME  = 3'd2;
   localparam logic [2:0] KIND_SAMPLE  = 3'd3;
   localparam logic [2:0] KIND_PLAY    = 3'd4;

   localparam logic [0:0] CSR_FIRST_CHAN  = 1'b0;
   localparam logic [0:0] CSR_SECOND_CHAN = 1'b1;

   localparam logic [4:0] FIRST_CHAN_RST  = 5'd16;
   localparam logic [4:0] SECOND_CHAN_RST = 5'd15;

   localparam logic [1:0] LEN_THREE = 2'd3;

   typedef enum logic [1:0] {
      EVT_MSG,
      EVT_VOL,
      EVT_SAMPLE,
      EVT_PLAY
   } evt_kind_type;

   // One classified event from the front end. For a sample, b0 holds the
   // doubled byte and num the address; for play, num holds the count.
   typedef struct packed {
      evt_kind_type kind;
      logic [7:0]   b0;
      logic [7:0]   b1;
      logic [7:0]   b2;
      logic [1:0]   len;
      logic [12:0]  num;
   } evt_type;

   // Expected manufacturer id bytes "CMM" at the head of a SysEx.
   function automatic logic [7:0] sysex_id(input logic [1:0] pos);
      logic [7:0] id;
      case (pos) inside
         2'd0:       id = 8'h43;
         2'd1, 2'd2: id = 8'h4D;
         default:    id = 8'h00;
      endcase
      return id;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/mbrs_front.sv =====
// Front end: accepts MIDI bytes, assembles channel messages and parses SysEx.
// Depends on mbrs_pkg; pushes classified events into mbrs_queue.
`default_nettype none

module mbrs_front #(
   parameter int unsigned SAMPLE_DEPTH = mbrs_pkg::SAMPLE_DEPTH_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire logic [7:0]       req_byte_in,
   input  wire logic             q_full,
   output logic                  q_push,
   output mbrs_pkg::evt_type     q_evt
);
   import mbrs_pkg::*;

   localparam int unsigned FILL_W = $clog2(SAMPLE_DEPTH + 1);

   logic              in_sysex_ff, in_sysex_in;
   logic [2:0]        sx_idx_ff, sx_idx_in;
   logic [7:0]        sx_cmd_ff, sx_cmd_in;
   logic              sx_ign_ff, sx_ign_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [7:0]        msg_ff [3];
   logic [7:0]        msg_in [3];
   logic [1:0]        pos_ff, pos_in;
   logic [1:0]        rem_ff, rem_in;
   logic [1:0]        len_ff, len_in;

   logic              fire;
   logic [31:0]       fill_ext;
   logic [1:0]        wr_idx;
   logic [1:0]        rem_new;
   logic [7:0]        c;

   assign req_ready = !q_full;
   assign fire      = req_valid && req_ready;
   assign c         = req_byte_in;
   assign fill_ext  = 32'(fill_ff);

   always_comb begin
      in_sysex_in = in_sysex_ff;
      sx_idx_in   = sx_idx_ff;
      sx_cmd_in   = sx_cmd_ff;
      sx_ign_in   = sx_ign_ff;
      fill_in     = fill_ff;
      msg_in      = msg_ff;
      pos_in      = pos_ff;
      rem_in      = rem_ff;
      len_in      = len_ff;
      q_push      = 1'b0;
      q_evt       = '0;
      q_evt.kind  = EVT_MSG;
      wr_idx      = (pos_ff == 2'd0) ? 2'd0 : ((pos_ff == 2'd1) ? 2'd1 : 2'd2);
      rem_new     = ((c[7:4] == NIB_PROGRAM) || (c[7:4] == NIB_PRESSURE)) ? 2'd1 : 2'd2;

      if (fire) begin
         if (in_sysex_ff) begin
            if (c == SYSEX_END) begin
               if ((sx_cmd_ff == CMD_SAMPLE) && (fill_ff != '0)) begin
                  q_push     = 1'b1;
                  q_evt.kind = EVT_PLAY;
                  q_evt.num  = fill_ext[12:0];
               end
               in_sysex_in = 1'b0;
               sx_idx_in   = '0;
               sx_cmd_in   = '0;
               sx_ign_in   = 1'b0;
               fill_in     = '0;
            end else if (!sx_ign_ff) begin
               if (sx_idx_ff < 3'd3) begin
                  if (c != sysex_id(sx_idx_ff[1:0])) begin
                     sx_ign_in = 1'b1;
                  end
               end else if (sx_idx_ff == 3'd3) begin
                  sx_cmd_in = c;
               end else if (sx_cmd_ff == CMD_VOLUME) begin
                  if (sx_idx_ff == 3'd4) begin
                     q_push     = 1'b1;
                     q_evt.kind = EVT_VOL;
                     q_evt.b0   = c;
                  end
               end else if (sx_cmd_ff == CMD_SAMPLE) begin
                  if (fill_ff < FILL_W'(SAMPLE_DEPTH)) begin
                     q_push     = 1'b1;
                     q_evt.kind = EVT_SAMPLE;
                     q_evt.b0   = {c[6:0], 1'b0};
                     q_evt.num  = {1'b0, fill_ext[11:0]};
                     fill_in    = fill_ff + FILL_W'(1);
                  end
               end
               if (sx_idx_ff < 3'd5) begin
                  sx_idx_in = sx_idx_ff + 3'd1;
               end
            end
         end else if (rem_ff != 2'd0) begin
            msg_in[wr_idx] = c;
            pos_in         = pos_ff + 2'd1;
            rem_in         = rem_ff - 2'd1;
            if (rem_ff == 2'd1) begin
               q_push     = 1'b1;
               q_evt.kind = EVT_MSG;
               q_evt.b0   = msg_in[0];
               q_evt.b1   = msg_in[1];
               q_evt.b2   = msg_in[2];
               q_evt.len  = len_ff;
            end
         end else if (c[7:4] == NIB_SYSTEM) begin
            if (c == SYSEX_START) begin
               in_sysex_in = 1'b1;
            end
         end else begin
            msg_in[0] = c;
            pos_in    = 2'd1;
            rem_in    = rem_new;
            len_in    = rem_new + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_sysex_ff <= 1'b0;
         sx_idx_ff   <= '0;
         sx_cmd_ff   <= '0;
         sx_ign_ff   <= 1'b0;
         fill_ff     <= '0;
         pos_ff      <= '0;
         rem_ff      <= '0;
         len_ff      <= '0;
      end else begin
         in_sysex_ff <= in_sysex_in;
         sx_idx_ff   <= sx_idx_in;
         sx_cmd_ff   <= sx_cmd_in;
         sx_ign_ff   <= sx_ign_in;
         fill_ff     <= fill_in;
         pos_ff      <= pos_in;
         rem_ff      <= rem_in;
         len_ff      <= len_in;
      end
   end

   // Message bytes are payload and are always written before they are read.
   always_ff @(posedge clock) begin
      msg_ff <= msg_in;
   end

endmodule

`default_nettype wire

// ===== rtl/core/mbrs_queue.sv =====
// Short event queue between the front end and the back end.
// Depends on mbrs_pkg and the assertion macros in midi_byte_receiver_sysex_assert.svh.
`default_nettype none

module mbrs_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire mbrs_pkg::evt_type  push_evt,
   input  wire logic               pop,
   output mbrs_pkg::evt_type       head_evt,
   output logic                    head_valid,
   output logic                    full
);
   import mbrs_pkg::*;
   `include "midi_byte_receiver_sysex_assert.svh"

   localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   evt_type           mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              do_push;
   logic              do_pop;

   assign head_valid = (cnt_ff != '0);
   assign full       = (cnt_ff == CNT_W'(QUEUE_DEPTH));
   assign head_evt   = mem_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_evt;
      end
   end

   // The front end must never offer a word when there is no room for it.
   `MBRS_ASSERT_SAME(a_no_push_full, push, !full, "event pushed into a full queue")
   `MBRS_ASSERT_SAME(a_no_pop_empty, pop, head_valid, "event popped from an empty queue")
   `MBRS_ASSERT_SAME(a_cnt_bound, 1'b1, cnt_ff <= CNT_W'(QUEUE_DEPTH), "queue count overflow")
   `MBRS_ASSERT_NEXT(a_cnt_drop, do_pop && !do_push, cnt_ff == $past(cnt_ff) - CNT_W'(1),
      "queue count did not fall after a pop")

endmodule

`default_nettype wire

// ===== rtl/core/mbrs_back.sv =====
// Back end: filters channel messages against the configured channels and
// formats each kept event into the registered result word. Depends on mbrs_pkg.
`default_nettype none

module mbrs_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_write_enable,
   input  wire logic [0:0]         csr_index,
   input  wire logic [4:0]         csr_write_data,
   input  wire mbrs_pkg::evt_type  head_evt,
   input  wire logic               head_valid,
   output logic                    pop,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [2:0]              rsp_event_kind,
   output logic [7:0]              rsp_msg_byte0,
   output logic [7:0]              rsp_msg_byte1,
   output logic [7:0]              rsp_msg_byte2,
   output logic [1:0]              rsp_msg_length,
   output logic [7:0]              rsp_note_number,
   output logic [7:0]              rsp_velocity,
   output logic                    rsp_on_first_channel,
   output logic [7:0]              rsp_volume_level,
   output logic [11:0]             rsp_sample_address,
   output logic [7:0]              rsp_sample_value,
   output logic [12:0]             rsp_sample_count
);
   import mbrs_pkg::*;

   logic [4:0]  first_chan_ff, first_chan_in;
   logic [4:0]  second_chan_ff, second_chan_in;
   logic        valid_ff, valid_in;
   logic [2:0]  kind_ff, kind_in;
   logic [7:0]  b0_ff, b0_in;
   logic [7:0]  b1_ff, b1_in;
   logic [7:0]  b2_ff, b2_in;
   logic [1:0]  len_ff, len_in;
   logic [7:0]  note_ff, note_in;
   logic [7:0]  vel_ff, vel_in;
   logic        first_ff, first_in;
   logic [7:0]  vol_ff, vol_in;
   logic [11:0] addr_ff, addr_in;
   logic [7:0]  sval_ff, sval_in;
   logic [12:0] count_ff, count_in;

   logic [4:0]  chan;
   logic        hit_first;
   logic        hit_local;
   logic        drop;
   logic        load;

   assign chan      = 5'd1 + {1'b0, head_evt.b0[3:0]};
   assign hit_first = (chan == first_chan_ff);
   assign hit_local = hit_first || (chan == second_chan_ff);

   // A local channel message other than a sounding note-on gives no result word.
   assign drop = (head_evt.kind == EVT_MSG) && hit_local &&
                 !((head_evt.b0[7:4] == NIB_NOTE_ON) && (head_evt.b2 != 8'd0));
   assign pop  = head_valid && (drop || !valid_ff || rsp_ready);
   assign load = pop && !drop;

   always_comb begin
      first_chan_in  = first_chan_ff;
      second_chan_in = second_chan_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_FIRST_CHAN:  first_chan_in  = csr_write_data;
            CSR_SECOND_CHAN: second_chan_in = csr_write_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      valid_in = valid_ff && !rsp_ready;
      kind_in  = kind_ff;
      b0_in    = b0_ff;
      b1_in    = b1_ff;
      b2_in    = b2_ff;
      len_in   = len_ff;
      note_in  = note_ff;
      vel_in   = vel_ff;
      first_in = first_ff;
      vol_in   = vol_ff;
      addr_in  = addr_ff;
      sval_in  = sval_ff;
      count_in = count_ff;
      if (load) begin
         valid_in = 1'b1;
         b0_in    = '0;
         b1_in    = '0;
         b2_in    = '0;
         len_in   = '0;
         note_in  = '0;
         vel_in   = '0;
         first_in = 1'b0;
         vol_in   = '0;
         addr_in  = '0;
         sval_in  = '0;
         count_in = '0;
         unique case (head_evt.kind)
            EVT_MSG: begin
               if (hit_local) begin
                  kind_in  = KIND_NOTE;
                  note_in  = head_evt.b1;
                  vel_in   = head_evt.b2;
                  first_in = hit_first;
               end else begin
                  kind_in = KIND_FORWARD;
                  b0_in   = head_evt.b0;
                  b1_in   = head_evt.b1;
                  b2_in   = (head_evt.len == LEN_THREE) ? head_evt.b2 : 8'd0;
                  len_in  = head_evt.len;
               end
            end
            EVT_VOL: begin
               kind_in = KIND_VOLUME;
               vol_in  = head_evt.b0;
            end
            EVT_SAMPLE: begin
               kind_in = KIND_SAMPLE;
               addr_in = head_evt.num[11:0];
               sval_in = head_evt.b0;
            end
            EVT_PLAY: begin
               kind_in  = KIND_PLAY;
               count_in = head_evt.num;
            end
            default: kind_in = KIND_FORWARD;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_chan_ff  <= FIRST_CHAN_RST;
         second_chan_ff <= SECOND_CHAN_RST;
         valid_ff       <= 1'b0;
      end else begin
         first_chan_ff  <= first_chan_in;
         second_chan_ff <= second_chan_in;
         valid_ff       <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      b0_ff    <= b0_in;
      b1_ff    <= b1_in;
      b2_ff    <= b2_in;
      len_ff   <= len_in;
      note_ff  <= note_in;
      vel_ff   <= vel_in;
      first_ff <= first_in;
      vol_ff   <= vol_in;
      addr_ff  <= addr_in;
      sval_ff  <= sval_in;
      count_ff <= count_in;
   end

   assign rsp_valid            = valid_ff;
   assign rsp_event_kind       = kind_ff;
   assign rsp_msg_byte0        = b0_ff;
   assign rsp_msg_byte1        = b1_ff;
   assign rsp_msg_byte2        = b2_ff;
   assign rsp_msg_length       = len_ff;
   assign rsp_note_number      = note_ff;
   assign rsp_velocity         = vel_ff;
   assign rsp_on_first_channel = first_ff;
   assign rsp_volume_level     = vol_ff;
   assign rsp_sample_address   = addr_ff;
   assign rsp_sample_value     = sval_ff;
   assign rsp_sample_count     = count_ff;

endmodule

`default_nettype wire

// ===== rtl/core/midi_byte_receiver_sysex.sv =====
// MIDI byte receiver with a SysEx side channel.
// One serial MIDI byte enters on the req_ channel per word. Channel messages
// are assembled; sounding note-ons on the two channels set by the csr_ port come
// out as note words, other traffic on those channels is dropped, and complete
// messages on any other channel are forwarded. A "CMM" SysEx can set the
// volume or upload sample bytes and request their playback at its end.
// Each result is a single word on the rsp_ channel with its event_kind.
// Throughput: one byte per cycle while req_ready is high. The front end
// classifies a byte in the cycle it is taken, a two-entry event queue
// follows, and the back end holds the result word in its output register.
// req_ready drops only when the event queue is full, which happens only while
// the receiver holds rsp_ready low; the output register then holds its word.
// Reset (synchronous, active high) clears the parser and the queue and sets
// the channel registers to 16 and 15. The user must write the channel
// registers only while no result is pending; the block does not enforce it.
// Depends on mbrs_pkg, mbrs_front, mbrs_queue and mbrs_back.
`default_nettype none

module midi_byte_receiver_sysex #(
   parameter int unsigned SAMPLE_DEPTH = mbrs_pkg::SAMPLE_DEPTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_byte_in,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_event_kind,
   output logic [7:0]       rsp_msg_byte0,
   output logic [7:0]       rsp_msg_byte1,
   output logic [7:0]       rsp_msg_byte2,
   output logic [1:0]       rsp_msg_length,
   output logic [7:0]       rsp_note_number,
   output logic [7:0]       rsp_velocity,
   output logic             rsp_on_first_channel,
   output logic [7:0]       rsp_volume_level,
   output logic [11:0]      rsp_sample_address,
   output logic [7:0]       rsp_sample_value,
   output logic [12:0]      rsp_sample_count,
   input  wire logic        csr_write_enable,
   input  wire logic [0:0]  csr_index,
   input  wire logic [4:0]  csr_write_data
);
   import mbrs_pkg::*;

   logic    q_full;
   logic    q_push;
   evt_type q_evt;
   evt_type head_evt;
   logic    head_valid;
   logic    q_pop;

   mbrs_front #(
      .SAMPLE_DEPTH(SAMPLE_DEPTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_byte_in(req_byte_in),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_evt      (q_evt)
   );

   mbrs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_evt  (q_evt),
      .pop       (q_pop),
      .head_evt  (head_evt),
      .head_valid(head_valid),
      .full      (q_full)
   );

   mbrs_back u_back (
      .clock               (clock),
      .reset               (reset),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data),
      .head_evt            (head_evt),
      .head_valid          (head_valid),
      .pop                 (q_pop),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_event_kind      (rsp_event_kind),
      .rsp_msg_byte0       (rsp_msg_byte0),
      .rsp_msg_byte1       (rsp_msg_byte1),
      .rsp_msg_byte2       (rsp_msg_byte2),
      .rsp_msg_length      (rsp_msg_length),
      .rsp_note_number     (rsp_note_number),
      .rsp_velocity        (rsp_velocity),
      .rsp_on_first_channel(rsp_on_first_channel),
      .rsp_volume_level    (rsp_volume_level),
      .rsp_sample_address  (rsp_sample_address),
      .rsp_sample_value    (rsp_sample_value),
      .rsp_sample_count    (rsp_sample_count)
   );

endmodule

`default_nettype wire
